### design/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

	localparam int COEF_W = 16;
	localparam int ROOT_W = 32;

	// square root: radicand d*2^16 below 2^49, padded to an even width
	localparam int SQ_RAD_W = 50;
	localparam int SQ_STEPS = SQ_RAD_W / 2;
	localparam int SQ_REM_W = SQ_STEPS + 2;

	// divider: dividend magnitude below 2^34, divisor magnitude up to 2^16
	localparam int DV_NUM_W = 34;
	localparam int DV_DEN_W = 17;
	localparam int DV_STEPS = DV_NUM_W;

	typedef enum logic [1:0] {
		ST_TWO   = 2'd0,
		ST_ONE   = 2'd1,
		ST_NONE  = 2'd2,
		ST_AZERO = 2'd3
	} status_t;

	typedef struct packed {
		logic                     opcode;
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
	} operands_t;

	typedef struct packed {
		logic signed [ROOT_W-1:0] first_root;
		logic signed [ROOT_W-1:0] second_root;
		status_t                  status;
		logic                     saturated;
	} result_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_STEPS-1:0] root;
		logic [SQ_RAD_W-1:0] rad;
	} sq_word_t;

	typedef struct packed {
		logic [DV_DEN_W-1:0] rem;
		logic [DV_NUM_W-1:0] nq;
		logic [DV_DEN_W-1:0] den;
	} dv_word_t;

	typedef struct packed {
		logic [ROOT_W-1:0] val;
		logic              sat;
	} clamp_t;

	// apply the sign to a quotient magnitude and clamp to the root range
	function automatic clamp_t clamp_root(input logic neg, input logic [DV_NUM_W-1:0] mag);
		clamp_t r;
		logic [DV_NUM_W-1:0] lim;
		lim = DV_NUM_W'(1) << (ROOT_W - 1);
		if (neg) begin
			if (mag > lim) begin
				r.val = {1'b1, {(ROOT_W-1){1'b0}}};
				r.sat = 1'b1;
			end else begin
				r.val = ROOT_W'(~mag + DV_NUM_W'(1));
				r.sat = 1'b0;
			end
		end else begin
			if (mag > lim - DV_NUM_W'(1)) begin
				r.val = {1'b0, {(ROOT_W-1){1'b1}}};
				r.sat = 1'b1;
			end else begin
				r.val = ROOT_W'(mag);
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/qrs_sqrt_cell.sv
`default_nettype none

// one restoring square-root step: two radicand bits in, one root bit out
module qrs_sqrt_cell (
	input  wire               clk,
	input  qrs_pkg::sq_word_t word_i,
	output qrs_pkg::sq_word_t word_o
);
	import qrs_pkg::*;

	logic [SQ_REM_W+1:0] trial_rem;
	logic [SQ_REM_W+1:0] trial_sub;
	logic                fits;

	always_comb begin
		trial_rem = {word_i.rem, word_i.rad[SQ_RAD_W-1 -: 2]};
		trial_sub = (SQ_REM_W+2)'({word_i.root, 2'b01});
		fits      = trial_rem >= trial_sub;
	end

	always_ff @(posedge clk) begin
		word_o.rem  <= fits ? SQ_REM_W'(trial_rem - trial_sub) : SQ_REM_W'(trial_rem);
		word_o.root <= {word_i.root[SQ_STEPS-2:0], fits};
		word_o.rad  <= word_i.rad << 2;
	end

endmodule

`default_nettype wire

### design/qrs_div_cell.sv
`default_nettype none

// one restoring division step: shift in a dividend bit, shift out a quotient bit
module qrs_div_cell (
	input  wire               clk,
	input  qrs_pkg::dv_word_t word_i,
	output qrs_pkg::dv_word_t word_o
);
	import qrs_pkg::*;

	logic [DV_DEN_W:0] trial_rem;
	logic              fits;

	always_comb begin
		trial_rem = {word_i.rem, word_i.nq[DV_NUM_W-1]};
		fits      = trial_rem >= {1'b0, word_i.den};
	end

	always_ff @(posedge clk) begin
		word_o.rem <= fits ? DV_DEN_W'(trial_rem - {1'b0, word_i.den}) : DV_DEN_W'(trial_rem);
		word_o.nq  <= {word_i.nq[DV_NUM_W-2:0], fits};
		word_o.den <= word_i.den;
	end

endmodule

`default_nettype wire

### design/quadratic_root_solver_unit.sv
`default_nettype none

// Channel   Ports             Handshake
// --------  ----------------  -----------------------------------------------
// command   start, operands   word taken on a rising edge with start & !busy
// result    done, result      word shown for one cycle while done is high
//
// Every word passes, from the accepting edge to the edge that takes its result,
// through two product/discriminant stages, 25 square-root cells, one numerator
// stage, 34 divider cells per root, and the output register.
// A new word may enter in every cycle; busy stays low.
// arst_n clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall: each result is presented exactly once.
module quadratic_root_solver_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  qrs_pkg::operands_t operands,
	output logic               done,
	output qrs_pkg::result_t   result
);
	import qrs_pkg::*;

	localparam int LAT = 4 + SQ_STEPS + DV_STEPS;

	typedef struct packed {
		logic                     op;
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic                     d_pos;
		logic                     d_neg;
	} sq_meta_t;

	typedef struct packed {
		status_t status;
		logic    neg1;
		logic    neg2;
	} dv_meta_t;

	// stage 1: products
	logic                     vld_s1;
	logic                     op_s1;
	logic signed [COEF_W-1:0] a_s1;
	logic signed [COEF_W-1:0] b_s1;
	logic signed [31:0]       bb_s1;
	logic signed [31:0]       ac_s1;

	// stage 2: discriminant and radicand
	logic signed [33:0] disc;

	// chains
	sq_word_t sq_w    [0:SQ_STEPS];
	sq_meta_t sq_m_q  [0:SQ_STEPS];
	logic     sq_v_q  [0:SQ_STEPS];
	dv_word_t dv1_w   [0:DV_STEPS];
	dv_word_t dv2_w   [0:DV_STEPS];
	dv_meta_t dv_m_q  [0:DV_STEPS];
	logic     dv_v_q  [0:DV_STEPS];

	// numerator stage signals
	sq_meta_t           nm;
	logic signed [26:0] nb;
	logic signed [26:0] root27;
	logic signed [26:0] num1;
	logic signed [26:0] num2;
	logic signed [35:0] div1;
	logic signed [35:0] div2;
	logic signed [17:0] den;
	logic [35:0]        mag1;
	logic [35:0]        mag2;
	logic [17:0]        den_mag;
	status_t            st_next;

	// output stage signals
	clamp_t   cl1;
	clamp_t   cl2;
	dv_meta_t om;
	result_t  res_next;

	// every stage takes a word each cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= operands.opcode;
		a_s1  <= operands.coef_a;
		b_s1  <= operands.coef_b;
		bb_s1 <= operands.coef_b * operands.coef_b;
		ac_s1 <= operands.coef_a * operands.coef_c;
	end

	// d = b*b - 4ac; only a positive d feeds the square root
	assign disc = 34'(bb_s1) - (34'(ac_s1) <<< 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_q[0] <= 1'b0;
		end else begin
			sq_v_q[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_m_q[0].op    <= op_s1;
		sq_m_q[0].a     <= a_s1;
		sq_m_q[0].b     <= b_s1;
		sq_m_q[0].d_pos <= (disc > 34'sd0);
		sq_m_q[0].d_neg <= disc[33];
		sq_w[0].rem     <= '0;
		sq_w[0].root    <= '0;
		sq_w[0].rad     <= (disc > 34'sd0) ? {1'b0, disc[32:0], 16'h0000} : '0;
	end

	// square-root chain; side data advances beside it
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		qrs_sqrt_cell u_cell (
			.clk    (clk),
			.word_i (sq_w[k]),
			.word_o (sq_w[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_q[k+1] <= 1'b0;
			end else begin
				sq_v_q[k+1] <= sq_v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_m_q[k+1] <= sq_m_q[k];
		end
	end

	// numerators -b*2^8 +/- sqrt(d*2^16), scaled by 2^8; linear uses -b*2^16 over a
	always_comb begin
		nm      = sq_m_q[SQ_STEPS];
		nb      = -(27'(nm.b) <<< 8);
		root27  = $signed({2'b00, sq_w[SQ_STEPS].root});
		num1    = nb + root27;
		num2    = nb - root27;
		div1    = nm.op ? (36'(num1) <<< 8) : -(36'(nm.b) <<< 16);
		div2    = 36'(num2) <<< 8;
		den     = nm.op ? (18'(nm.a) <<< 1) : 18'(nm.a);
		mag1    = div1[35] ? 36'(-div1) : 36'(div1);
		mag2    = div2[35] ? 36'(-div2) : 36'(div2);
		den_mag = den[17] ? 18'(-den) : 18'(den);
		if (nm.a == '0) begin
			st_next = ST_AZERO;
		end else if (!nm.op) begin
			st_next = ST_ONE;
		end else if (nm.d_pos) begin
			st_next = ST_TWO;
		end else if (nm.d_neg) begin
			st_next = ST_NONE;
		end else begin
			st_next = ST_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_q[0] <= 1'b0;
		end else begin
			dv_v_q[0] <= sq_v_q[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		dv_m_q[0].status <= st_next;
		dv_m_q[0].neg1   <= div1[35] ^ den[17];
		dv_m_q[0].neg2   <= div2[35] ^ den[17];
		dv1_w[0].rem     <= '0;
		dv1_w[0].nq      <= mag1[DV_NUM_W-1:0];
		dv1_w[0].den     <= den_mag[DV_DEN_W-1:0];
		dv2_w[0].rem     <= '0;
		dv2_w[0].nq      <= mag2[DV_NUM_W-1:0];
		dv2_w[0].den     <= den_mag[DV_DEN_W-1:0];
	end

	// two divider chains, one per root, in lockstep
	for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
		qrs_div_cell u_cell1 (
			.clk    (clk),
			.word_i (dv1_w[k]),
			.word_o (dv1_w[k+1])
		);

		qrs_div_cell u_cell2 (
			.clk    (clk),
			.word_i (dv2_w[k]),
			.word_o (dv2_w[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_q[k+1] <= 1'b0;
			end else begin
				dv_v_q[k+1] <= dv_v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_m_q[k+1] <= dv_m_q[k];
		end
	end

	// sign, clamp, and drop roots that the status does not report
	always_comb begin
		om  = dv_m_q[DV_STEPS];
		cl1 = clamp_root(om.neg1, dv1_w[DV_STEPS].nq);
		cl2 = clamp_root(om.neg2, dv2_w[DV_STEPS].nq);
		res_next.status = om.status;
		case (om.status)
			ST_TWO: begin
				res_next.first_root  = cl1.val;
				res_next.second_root = cl2.val;
				res_next.saturated   = cl1.sat | cl2.sat;
			end
			ST_ONE: begin
				res_next.first_root  = cl1.val;
				res_next.second_root = '0;
				res_next.saturated   = cl1.sat;
			end
			default: begin
				res_next.first_root  = '0;
				res_next.second_root = '0;
				res_next.saturated   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v_q[DV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		result <= res_next;
	end

`ifndef SYNTHESIS
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result word missing after fixed latency");

	a_no_root_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_NONE || result.status == ST_AZERO)
		|-> result.first_root == '0 && result.second_root == '0 && !result.saturated)
		else $error("roots reported without a real root");

	a_one_root : assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_ONE |-> result.second_root == '0)
		else $error("second root set for a single root");

	a_never_busy : assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
`endif

endmodule

`default_nettype wire

### test/qrs_checker.sv
`timescale 1ns / 1ps

module qrs_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                busy,
	input  qrs_pkg::operands_t operands,
	input  wire                done,
	input  qrs_pkg::result_t   result,
	output int                 fail_count,
	output int                 pending,
	output int                 taken_count
);
	import qrs_pkg::*;

	result_t root_queue[$];

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint sat_root(input longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic result_t solve_roots(input operands_t op);
		result_t r;
		longint a, b, c, d, nb, s;
		logic sat;
		a = op.coef_a;
		b = op.coef_b;
		c = op.coef_c;
		sat = 1'b0;
		r.first_root = '0;
		r.second_root = '0;
		if (a == 0) begin
			r.status = ST_AZERO;
		end else if (!op.opcode) begin
			r.first_root = 32'(sat_root((-b * 65536) / a, sat));
			r.status = ST_ONE;
		end else begin
			d = b * b - 4 * a * c;
			nb = -b * 256;
			if (d > 0) begin
				s = longint'(isqrt(64'(d) * 65536));
				r.first_root = 32'(sat_root(((nb + s) * 256) / (2 * a), sat));
				r.second_root = 32'(sat_root(((nb - s) * 256) / (2 * a), sat));
				r.status = ST_TWO;
			end else if (d < 0) begin
				r.status = ST_NONE;
			end else begin
				r.first_root = 32'(sat_root((nb * 256) / (2 * a), sat));
				r.status = ST_ONE;
			end
		end
		r.saturated = sat;
		return r;
	endfunction

	assign pending = root_queue.size();

	// predict on every accepted word, compare on every strobe
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (root_queue.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, result);
					fail_count++;
				end else begin
					want = root_queue.pop_front();
					if (want.first_root !== result.first_root) begin
						$display("%0t: first_root expected %h actual %h", $time,
							want.first_root, result.first_root);
						fail_count++;
					end
					if (want.second_root !== result.second_root) begin
						$display("%0t: second_root expected %h actual %h", $time,
							want.second_root, result.second_root);
						fail_count++;
					end
					if (want.status !== result.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, result.status);
						fail_count++;
					end
					if (want.saturated !== result.saturated) begin
						$display("%0t: saturated expected %b actual %b", $time,
							want.saturated, result.saturated);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				root_queue.push_back(solve_roots(operands));
				taken_count++;
			end
		end
	end
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import qrs_pkg::*;

	localparam int LATENCY = 63;
	localparam int WATCHDOG = 2000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	operands_t operands = '0;
	wire       busy;
	wire       done;
	result_t   result;
	int        fail_count, pending, taken_count;
	int        idle_pct;
	int        quiet_cycles;

	always #4 clk = ~clk;

	quadratic_root_solver_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	qrs_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operands(operands),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending),
		.taken_count(taken_count)
	);

	// count cycles in which no word moves in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// present one word at the falling edge and hold it until it is taken
	task automatic send_word(input operands_t w);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operands <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_coefs(input logic op, input int a, input int b, input int c);
		operands_t w;
		w.opcode = op;
		w.coef_a = 16'(a);
		w.coef_b = 16'(b);
		w.coef_c = 16'(c);
		send_word(w);
	endtask

	// random coefficient sets, some biased: zero or small a, small values, repeated roots
	function automatic operands_t random_word();
		operands_t w;
		int k;
		w = operands_t'({$urandom, $urandom});
		k = $urandom_range(9, 0);
		case (k)
			0: w.coef_a = 16'sd0;
			1: begin
				w.coef_a = 16'($urandom_range(511, 0)) - 16'sd256;
				w.coef_b = 16'($urandom_range(2047, 0)) - 16'sd1024;
				w.coef_c = 16'($urandom_range(2047, 0)) - 16'sd1024;
			end
			2: begin
				// repeated root when b*b == 4ac: c = b*b/(4a), set to zero if the division is not exact
				w.coef_a = 16'($urandom_range(100, 1));
				w.coef_b = 16'(2 * $urandom_range(100, 1));
				w.coef_c = 16'((int'(w.coef_b) * int'(w.coef_b)) / (4 * int'(w.coef_a)));
				if (int'(w.coef_b) * int'(w.coef_b) != 4 * int'(w.coef_a) * int'(w.coef_c))
					w.coef_c = 16'sd0;
				w.opcode = 1'b1;
			end
			3: w.coef_a = 16'($urandom_range(3, 0)) - 16'sd1;
			default: ;
		endcase
		if (w.coef_a == 0 && k != 0 && $urandom_range(1, 0)) w.coef_a = 16'sd1;
		return w;
	endfunction

	initial begin
		int n;
		idle_pct = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, both modes, each outcome
		send_coefs(1'b0, 0, 5, 7);
		send_coefs(1'b1, 0, 5, 7);
		send_coefs(1'b0, 256, 512, 0);
		send_coefs(1'b0, 1, -32768, 0);
		send_coefs(1'b0, 1, 32767, 0);
		send_coefs(1'b0, -1, -32768, 0);
		send_coefs(1'b0, -32768, 32767, -1);
		send_coefs(1'b0, 32767, -32768, 0);
		send_coefs(1'b1, 256, 0, -256);
		send_coefs(1'b1, 256, 512, 256);
		send_coefs(1'b1, 256, 0, 256);
		send_coefs(1'b1, 1, -32768, -32768);
		send_coefs(1'b1, 1, 32767, 32767);
		send_coefs(1'b1, -32768, -32768, 32767);
		send_coefs(1'b1, -32768, 32767, -32768);
		send_coefs(1'b1, 32767, -32768, -32768);
		send_coefs(1'b1, -1, 0, 32767);
		send_coefs(1'b1, 1, 0, 0);
		send_coefs(1'b1, -32768, 0, 0);

		// random phases: no idling, sender gaps, receiver phase (cannot stall), light gaps
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 72 : ((ph == 3) ? 28 : 0);
			for (n = 0; n < 250; n++) send_word(random_word());
		end
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		$display("Covered %0d coefficient sets in linear and quadratic modes,", taken_count);
		$display("with zero leading terms, repeated, complex and saturated roots.");
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule

### sim.f
design/qrs_pkg.sv
design/qrs_sqrt_cell.sv
design/qrs_div_cell.sv
design/quadratic_root_solver_unit.sv
test/qrs_checker.sv
test/tb_top.sv
